### sv/pcle_pkg.sv
package pcle_pkg;

   // Store size and the widths that follow from it
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Field widths of the transactions
   localparam int ACTION_W = 3;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 5;

   typedef logic [ACTION_W-1:0]       action_type;
   typedef logic [POS_W-1:0]          position_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [STATUS_W-1:0]       status_type;
   typedef logic [LEN_W-1:0]          length_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [CNT_W-1:0]          count_type;

   // Action codes
   localparam action_type ACT_INS_FRONT = 3'd0;
   localparam action_type ACT_INS_BACK  = 3'd1;
   localparam action_type ACT_INS_POS   = 3'd2;
   localparam action_type ACT_DEL_FRONT = 3'd3;
   localparam action_type ACT_DEL_BACK  = 3'd4;
   localparam action_type ACT_DEL_POS   = 3'd5;
   localparam action_type ACT_TRAVERSE  = 3'd6;

   // Status codes
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_EMPTY  = 2'd1;
   localparam status_type ST_BADPOS = 2'd2;
   localparam status_type ST_FULL   = 2'd3;

   // Cell operations, broadcast along the chain
   typedef logic [1:0] cell_op_type;
   localparam cell_op_type CELL_HOLD = 2'd0;
   localparam cell_op_type CELL_INS  = 2'd1;
   localparam cell_op_type CELL_DEL  = 2'd2;
   localparam cell_op_type CELL_ROT  = 2'd3;

   typedef struct packed {
      cell_op_type op;
      idx_type     idx;
      value_type   value;
   } cell_ctrl_type;

endpackage

### sv/pcle_req_if.sv
interface pcle_req_if;
   logic                   valid;
   logic                   ready;
   pcle_pkg::action_type   action;
   pcle_pkg::position_type position;
   pcle_pkg::value_type    value;

   modport source (output valid, output action, output position, output value, input ready);
   modport sink   (input valid, input action, input position, input value, output ready);
endinterface

### sv/pcle_rsp_if.sv
interface pcle_rsp_if;
   logic                 valid;
   logic                 ready;
   pcle_pkg::status_type status;
   pcle_pkg::value_type  item_value;
   logic                 last;
   pcle_pkg::length_type length;

   modport source (output valid, output status, output item_value, output last,
                   output length, input ready);
   modport sink   (input valid, input status, input item_value, input last,
                   input length, output ready);
endinterface

### sv/pcle_cell.sv
// One list position. Cell i holds the element at 1-based position i+1.
module pcle_cell (
   input  logic                    clock,
   input  pcle_pkg::idx_type       cell_idx,
   input  pcle_pkg::cell_ctrl_type ctrl,
   input  pcle_pkg::value_type     left_val,
   input  pcle_pkg::value_type     right_val,
   input  pcle_pkg::value_type     first_val,
   output pcle_pkg::value_type     val
);

   pcle_pkg::value_type val_ff;
   pcle_pkg::value_type val_in;

   always_comb begin
      val_in = val_ff;
      unique case (ctrl.op)
         pcle_pkg::CELL_HOLD: val_in = val_ff;
         pcle_pkg::CELL_INS: begin
            // open a gap at the insert point, shift the tail one place on
            if (cell_idx > ctrl.idx)
               val_in = left_val;
            else if (cell_idx == ctrl.idx)
               val_in = ctrl.value;
         end
         pcle_pkg::CELL_DEL: begin
            // close the gap: pull from the right neighbour
            if (cell_idx >= ctrl.idx)
               val_in = right_val;
         end
         pcle_pkg::CELL_ROT: begin
            // rotate the occupied part; idx is the last occupied cell
            if (cell_idx < ctrl.idx)
               val_in = right_val;
            else if (cell_idx == ctrl.idx)
               val_in = first_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val = val_ff;

endmodule

### sv/positional_circular_list_engine.sv
// Channel   Dir  Payload                               Transaction when
// req_chan  in   action, position, value               valid && ready
// rsp_chan  out  status, item_value, last, length      valid && ready
//
// Insert, delete and unused actions give one result each.
// Traverse gives one result per element, one per cycle while rsp_chan is
// not stalled. The rotation of the cell chain (one shift per element) sets
// that figure; req_chan is not ready again until the walk has ended.
// Reset clears the length and the walk state; no clearing pass.
// A stall on rsp_chan holds the result register and freezes the walk.
module positional_circular_list_engine (
   input  logic          clock,
   input  logic          reset,
   pcle_req_if.sink      req_chan,
   pcle_rsp_if.source    rsp_chan
);

   localparam int CMP_W = ((pcle_pkg::CNT_W > pcle_pkg::POS_W) ?
                           pcle_pkg::CNT_W : pcle_pkg::POS_W) + 1;

   localparam logic FSM_IDLE = 1'b0;
   localparam logic FSM_WALK = 1'b1;

   // Control state
   logic                  state_ff, state_in;
   pcle_pkg::count_type   count_ff, count_in;
   pcle_pkg::idx_type     walk_ff, walk_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Result payload
   pcle_pkg::status_type  rsp_status_ff, rsp_status_in;
   pcle_pkg::value_type   rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   pcle_pkg::length_type  rsp_length_ff, rsp_length_in;

   // Chain
   pcle_pkg::cell_ctrl_type ctrl;
   pcle_pkg::value_type     cell_val [pcle_pkg::CAPACITY];

   // Decode
   pcle_pkg::cell_op_type dec_op;
   pcle_pkg::idx_type     dec_idx;
   pcle_pkg::status_type  dec_status;
   logic                  dec_walk;

   logic [CMP_W-1:0]      pos_w;
   logic [CMP_W-1:0]      cnt_w;
   logic                  full;
   logic                  empty;
   pcle_pkg::idx_type     last_idx;
   logic                  out_free;
   logic                  req_fire;
   logic                  walk_emit;
   logic                  walk_last;

   assign pos_w    = CMP_W'(req_chan.position);
   assign cnt_w    = CMP_W'(count_ff);
   assign full     = (count_ff == pcle_pkg::CNT_W'(pcle_pkg::CAPACITY));
   assign empty    = (count_ff == '0);
   assign last_idx = pcle_pkg::IDX_W'(count_ff - pcle_pkg::CNT_W'(1));

   // The result register may take a new transaction when empty or draining
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == FSM_IDLE) && out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign walk_emit = (state_ff == FSM_WALK) && out_free;
   assign walk_last = (walk_ff == last_idx);

   // Work out the action; the position check comes before the full check
   always_comb begin
      dec_op     = pcle_pkg::CELL_HOLD;
      dec_idx    = '0;
      dec_status = pcle_pkg::ST_OK;
      dec_walk   = 1'b0;
      unique case (req_chan.action)
         pcle_pkg::ACT_INS_FRONT: begin
            if (full) dec_status = pcle_pkg::ST_FULL;
            else dec_op = pcle_pkg::CELL_INS;
         end
         pcle_pkg::ACT_INS_BACK: begin
            if (full) begin
               dec_status = pcle_pkg::ST_FULL;
            end else begin
               dec_op  = pcle_pkg::CELL_INS;
               dec_idx = pcle_pkg::IDX_W'(count_ff);
            end
         end
         pcle_pkg::ACT_INS_POS: begin
            if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) begin
               dec_status = pcle_pkg::ST_BADPOS;
            end else if (full) begin
               dec_status = pcle_pkg::ST_FULL;
            end else begin
               dec_op  = pcle_pkg::CELL_INS;
               dec_idx = pcle_pkg::IDX_W'(pos_w - CMP_W'(1));
            end
         end
         pcle_pkg::ACT_DEL_FRONT: begin
            if (empty) dec_status = pcle_pkg::ST_EMPTY;
            else dec_op = pcle_pkg::CELL_DEL;
         end
         pcle_pkg::ACT_DEL_BACK: begin
            if (empty) begin
               dec_status = pcle_pkg::ST_EMPTY;
            end else begin
               dec_op  = pcle_pkg::CELL_DEL;
               dec_idx = last_idx;
            end
         end
         pcle_pkg::ACT_DEL_POS: begin
            // position one on an empty list reports empty, not a bad position
            if (pos_w == CMP_W'(1) && empty) begin
               dec_status = pcle_pkg::ST_EMPTY;
            end else if (pos_w == '0 || pos_w > cnt_w) begin
               dec_status = pcle_pkg::ST_BADPOS;
            end else begin
               dec_op  = pcle_pkg::CELL_DEL;
               dec_idx = pcle_pkg::IDX_W'(pos_w - CMP_W'(1));
            end
         end
         pcle_pkg::ACT_TRAVERSE: begin
            if (empty) dec_status = pcle_pkg::ST_EMPTY;
            else dec_walk = 1'b1;
         end
         default: begin
            // unused code: acknowledge, change nothing
            dec_status = pcle_pkg::ST_OK;
         end
      endcase
   end

   // Drive the chain: apply the edit on accept, rotate once per walk step
   always_comb begin
      ctrl.op    = pcle_pkg::CELL_HOLD;
      ctrl.idx   = dec_idx;
      ctrl.value = req_chan.value;
      if (req_fire) begin
         ctrl.op = dec_op;
      end else if (walk_emit) begin
         ctrl.op  = pcle_pkg::CELL_ROT;
         ctrl.idx = last_idx;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < pcle_pkg::CAPACITY; gi++) begin : g_cell
         pcle_pkg::value_type left_v;
         pcle_pkg::value_type right_v;
         if (gi == 0) begin : g_lo
            assign left_v = '0;
         end else begin : g_lo
            assign left_v = cell_val[gi-1];
         end
         if (gi == pcle_pkg::CAPACITY - 1) begin : g_hi
            assign right_v = '0;
         end else begin : g_hi
            assign right_v = cell_val[gi+1];
         end
         pcle_cell u_cell (
            .clock     (clock),
            .cell_idx  (pcle_pkg::IDX_W'(gi)),
            .ctrl      (ctrl),
            .left_val  (left_v),
            .right_val (right_v),
            .first_val (cell_val[0]),
            .val       (cell_val[gi])
         );
      end
   endgenerate

   // Next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_length_in = rsp_length_ff;
      if (req_fire) begin
         if (dec_op == pcle_pkg::CELL_INS)
            count_in = count_ff + pcle_pkg::CNT_W'(1);
         else if (dec_op == pcle_pkg::CELL_DEL)
            count_in = count_ff - pcle_pkg::CNT_W'(1);
         if (dec_walk) begin
            // results come from the walk; hold the output side for now
            state_in = FSM_WALK;
            walk_in  = '0;
         end else begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = dec_status;
            rsp_value_in  = '0;
            rsp_last_in   = 1'b1;
            rsp_length_in = pcle_pkg::LEN_W'(count_in);
         end
      end else if (walk_emit) begin
         // emit the head cell, then advance
         rsp_valid_in  = 1'b1;
         rsp_status_in = pcle_pkg::ST_OK;
         rsp_value_in  = cell_val[0];
         rsp_last_in   = walk_last;
         rsp_length_in = pcle_pkg::LEN_W'(count_ff);
         walk_in       = walk_ff + pcle_pkg::IDX_W'(1);
         if (walk_last)
            state_in = FSM_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.item_value = rsp_value_ff;
   assign rsp_chan.last       = rsp_last_ff;
   assign rsp_chan.length     = rsp_length_ff;

   // The list never grows past the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pcle_pkg::CNT_W'(pcle_pkg::CAPACITY))
      else $error("list length beyond capacity");

   // A walk only runs over a non-empty list and leaves the length alone
   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_WALK) |-> (count_ff != '0))
      else $error("walk on an empty list");

   a_walk_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_WALK) |=> $stable(count_ff))
      else $error("length changed during a walk");

   // Only a walk produces results that are not the last of their transaction
   a_not_last_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff && rsp_chan.ready) |-> (state_ff == FSM_WALK))
      else $error("intermediate result outside a walk");

   // The final walk step returns to idle
   a_walk_end: assert property (@(posedge clock) disable iff (reset)
      (walk_emit && walk_last) |=> (state_ff == FSM_IDLE))
      else $error("walk did not finish after its last element");

endmodule
